>>> hw/rtl/bbir_pkg.sv
// bbir_pkg: shared types and constants for the byte buffer insert/remove core
// command and status codes, cell operation, sequencer states, word structs
// no dependencies
package bbir_pkg;

  // default number of byte cells
  localparam int BBIR_CAPACITY = 256;
  // read-out groups: cells are or-reduced in groups of this size
  localparam int GRP    = 16;
  localparam int GRP_SH = 4;
  // index width wide enough for the largest supported capacity
  localparam int IDX_W  = 13;

  // command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_APPEND = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_CLR
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_RD_LOAD,
    S_RD_WALK
  } bbir_state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [8:0] position;
    logic [7:0] data_byte;
    logic [8:0] length;
  } bbir_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic [8:0] fill_level;
  } bbir_out_t;

  // control broadcast from the sequencer to the cell row and read-out groups
  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
    logic [7:0]       data;
    logic             grp_load;
    logic             grp_shift;
  } bbir_ctl_t;

endpackage

>>> hw/rtl/bbir_cell.sv
// bbir_cell: one byte slot of the cell row
// takes from its lower or upper neighbor on insert and remove shifts
// depends on bbir_pkg
module bbir_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bbir_pkg::bbir_ctl_t ctl,
  input  logic [7:0]         lower_byte,
  input  logic [7:0]         upper_byte,
  output logic [7:0]         byte_q
);
  import bbir_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       at_pos;
  logic       above_pos;

  assign at_pos    = (ctl.pos == IDX_W'(IDX));
  assign above_pos = (IDX_W'(IDX) > ctl.pos);

  // next byte for this slot
  always_comb begin
    byte_nxt = byte_r;
    unique case (ctl.op)
      CELL_INS: begin
        if (above_pos) begin
          byte_nxt = lower_byte;
        end else if (at_pos) begin
          byte_nxt = ctl.data;
        end
      end
      CELL_DEL: begin
        if (above_pos || at_pos) begin
          byte_nxt = upper_byte;
        end
      end
      CELL_CLR:  byte_nxt = 8'h00;
      CELL_HOLD: byte_nxt = byte_r;
      default:   byte_nxt = byte_r;
    endcase
  end

  // slot register, empty after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_q = byte_r;

endmodule

>>> hw/rtl/bbir_ctrl.sv
// bbir_ctrl: command decode, fill level and shift/read sequencer
// drives the control struct of the cell row and builds the result word
// depends on bbir_pkg
module bbir_ctrl #(
  parameter int CAPACITY = bbir_pkg::BBIR_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bbir_pkg::bbir_in_t  in_item,
  input  logic [7:0]          grp0_byte,
  output bbir_pkg::bbir_ctl_t ctl,
  output logic                out_valid,
  output bbir_pkg::bbir_out_t out_item
);
  import bbir_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CW > 10) ? CW : 10;

  bbir_state_t state_r, state_nxt;
  logic [CW-1:0] used_r;
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] pos_r;
  cell_op_t      op_r;
  logic [7:0]    byte_r;
  logic          out_valid_r;
  bbir_out_t     res_r;

  logic          accept;
  logic [AW-1:0] used_a, pos_a, len_a, cap_a, ins_pos, room, tail, rm_cnt;
  logic [1:0]    dec_status;
  logic [AW-1:0] dec_used, dec_pos, dec_cnt;
  logic          dec_shift, dec_read, dec_clear;
  cell_op_t      dec_op;
  logic          done;

  assign accept  = start && (state_r == S_IDLE);
  assign used_a  = AW'(used_r);
  assign pos_a   = AW'(in_item.position);
  assign len_a   = AW'(in_item.length);
  assign cap_a   = AW'(CAPACITY);
  assign ins_pos = (in_item.cmd == CMD_APPEND) ? used_a : pos_a;
  assign room    = cap_a - used_a;
  assign tail    = used_a - pos_a;
  assign rm_cnt  = (len_a > tail) ? tail : len_a;

  // command decode and range checks
  always_comb begin
    dec_status = ST_OK;
    dec_used   = used_a;
    dec_pos    = pos_a;
    dec_cnt    = '0;
    dec_shift  = 1'b0;
    dec_read   = 1'b0;
    dec_clear  = 1'b0;
    dec_op     = CELL_HOLD;
    unique case (in_item.cmd)
      CMD_INSERT, CMD_APPEND: begin
        priority if (ins_pos > used_a) begin
          dec_status = ST_RANGE;
        end else if (len_a == '0) begin
          dec_status = ST_OK;
        end else if (room < len_a) begin
          dec_status = ST_FULL;
        end else begin
          dec_shift = 1'b1;
          dec_op    = CELL_INS;
          dec_pos   = ins_pos;
          dec_cnt   = len_a;
          dec_used  = used_a + len_a;
        end
      end
      CMD_REMOVE: begin
        priority if (pos_a >= used_a) begin
          dec_status = ST_RANGE;
        end else if (rm_cnt == '0) begin
          dec_status = ST_OK;
        end else begin
          dec_shift = 1'b1;
          dec_op    = CELL_DEL;
          dec_cnt   = rm_cnt;
          dec_used  = used_a - rm_cnt;
        end
      end
      CMD_CLEAR: begin
        dec_clear = 1'b1;
        dec_used  = '0;
      end
      CMD_READ: begin
        if (pos_a >= used_a) begin
          dec_status = ST_RANGE;
        end else begin
          dec_read = 1'b1;
          dec_cnt  = pos_a >> GRP_SH;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && dec_shift) begin
          state_nxt = S_SHIFT;
        end else if (accept && dec_read) begin
          state_nxt = S_RD_LOAD;
        end
      end
      S_SHIFT: begin
        if (cnt_r == AW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_LOAD: state_nxt = S_RD_WALK;
      S_RD_WALK: begin
        if (cnt_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs toward the cell row and the handshake
  always_comb begin
    busy          = (state_r != S_IDLE);
    ctl.op        = CELL_HOLD;
    ctl.pos       = IDX_W'(pos_r);
    ctl.data      = byte_r;
    ctl.grp_load  = 1'b0;
    ctl.grp_shift = 1'b0;
    done          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && dec_clear) begin
          ctl.op = CELL_CLR;
        end
        done = accept && !dec_shift && !dec_read;
      end
      S_SHIFT: begin
        ctl.op = op_r;
        done   = (cnt_r == AW'(1));
      end
      S_RD_LOAD: ctl.grp_load = 1'b1;
      S_RD_WALK: begin
        ctl.grp_shift = 1'b1;
        done          = (cnt_r == '0);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= done;
      if (accept) begin
        used_r <= CW'(dec_used);
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r.status     <= dec_status;
      res_r.read_data  <= 8'h00;
      res_r.fill_level <= 9'(dec_used);
      op_r             <= dec_op;
      pos_r            <= dec_pos;
      byte_r           <= in_item.data_byte;
      cnt_r            <= dec_cnt;
    end else if (state_r == S_SHIFT) begin
      cnt_r <= cnt_r - AW'(1);
    end else if (state_r == S_RD_WALK) begin
      if (cnt_r == '0) begin
        res_r.read_data <= grp0_byte;
      end else begin
        cnt_r <= cnt_r - AW'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = res_r;

endmodule

>>> hw/rtl/byte_buffer_insert_remove_core.sv
// byte_buffer_insert_remove_core: editable byte string held in a row of byte cells
// instantiates bbir_ctrl and bbir_cell; depends on bbir_pkg
//
// usage:
//   a command word (cmd, position, data_byte, length) is taken at a rising edge with
//   start high and busy low. busy stays high while the command is being worked on.
//   each command gives one result word (status, read_data, fill_level) on out_item,
//   shown for exactly one cycle with out_valid high; the receiver cannot stall it.
// how each command is worked on:
//   insert / append : the cell row moves the tail up one slot a cycle
//   remove          : min(length, bytes from position to end) bytes go, one slot a cycle
//   read            : cells are or-reduced in groups of 16, the addressed group is loaded,
//                     and the group registers walk down to the read-out end
//   clear, errors, zero length and unused codes : result shown in the cycle after the accept edge
//   a new command may be started in the cycle the result is shown.
// reset (synchronous, active low) empties every cell and sets the fill level to zero;
// no clearing pass is needed.
module byte_buffer_insert_remove_core #(
  parameter int CAPACITY = bbir_pkg::BBIR_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bbir_pkg::bbir_in_t  in_item,
  output logic                out_valid,
  output bbir_pkg::bbir_out_t out_item
);
  import bbir_pkg::*;

  localparam int G    = (CAPACITY + GRP - 1) / GRP;
  localparam int NPAD = G * GRP + 1;

  bbir_ctl_t  ctl;
  logic [7:0] cell_q [NPAD];
  logic [7:0] grp_r  [G];

  // sequencer
  bbir_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .grp0_byte(grp_r[0]),
    .ctl      (ctl),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // cell row, padded with zero slots up to the group boundary and one slot beyond it
  for (genvar i = 0; i < NPAD; i++) begin : g_cell
    if (i < CAPACITY) begin : g_real
      logic [7:0] lower_b;
      if (i == 0) begin : g_first
        assign lower_b = 8'h00;
      end else begin : g_mid
        assign lower_b = cell_q[i-1];
      end
      bbir_cell #(
        .IDX(i)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .lower_byte(lower_b),
        .upper_byte(cell_q[i+1]),
        .byte_q    (cell_q[i])
      );
    end else begin : g_pad
      assign cell_q[i] = 8'h00;
    end
  end

  // read-out groups: select the addressed byte, then walk toward group zero
  for (genvar g = 0; g < G; g++) begin : g_grp
    localparam int BASE = g * GRP;
    logic [7:0] grp_or;
    logic [7:0] grp_next_in;

    always_comb begin
      grp_or = 8'h00;
      for (int k = 0; k < GRP; k++) begin
        if (ctl.pos == IDX_W'(BASE + k)) begin
          grp_or = grp_or | cell_q[BASE + k];
        end
      end
    end

    if (g == G - 1) begin : g_last
      assign grp_next_in = 8'h00;
    end else begin : g_link
      assign grp_next_in = grp_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (ctl.grp_load) begin
        grp_r[g] <= grp_or;
      end else if (ctl.grp_shift) begin
        grp_r[g] <= grp_next_in;
      end
    end
  end

endmodule

>>> hw/rtl/bbir_chk.sv
// bbir_chk: port-level checks for byte_buffer_insert_remove_core, bound to the top level
// watches the command and result words only; depends on bbir_pkg
module bbir_chk #(
  parameter int CAPACITY = bbir_pkg::BBIR_CAPACITY
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input bbir_pkg::bbir_in_t  in_item,
  input logic                out_valid,
  input bbir_pkg::bbir_out_t out_item
);
  import bbir_pkg::*;

  // status word only carries the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK || out_item.status == ST_RANGE ||
                   out_item.status == ST_FULL))
    else $error("bbir: undefined status code");

  // a failed command never returns a byte
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> (out_item.read_data == 8'h00))
    else $error("bbir: read data on failed command");

  // fill level stays within the store
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((CAPACITY > 511) || (int'(out_item.fill_level) <= CAPACITY)))
    else $error("bbir: fill level above capacity");

  // clear answers in the next cycle with an empty string
  a_clear_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == CMD_CLEAR) |=>
      (out_valid && out_item.status == ST_OK && out_item.fill_level == 9'd0))
    else $error("bbir: clear response wrong");

endmodule

bind byte_buffer_insert_remove_core bbir_chk #(
  .CAPACITY(CAPACITY)
) u_bbir_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);

>>> tb/sv/byte_buffer_insert_remove_core_tb.sv
// byte_buffer_insert_remove_core_tb: self-checking bench for the byte buffer insert/remove core
// drives command words in random bursts and checks each result word against a local string model
// depends on bbir_pkg and byte_buffer_insert_remove_core
`timescale 1ns / 100ps

module byte_buffer_insert_remove_core_tb;
  import bbir_pkg::*;

  localparam int CAP          = BBIR_CAPACITY;
  localparam int RANDOM_WORDS = 1525;
  localparam int TAIL_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 2000000;

  // command codes the core treats as no operation
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  bbir_in_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  bbir_out_t out_item;

  // string model: byte image and fill count after every accepted word
  logic [7:0]  byte_image [CAP];
  int unsigned fill_count = 0;

  bbir_in_t  command_queue [$];
  bbir_out_t awaited_words [$];
  logic      word_taken     = 1'b0;
  int        burst_left     = 0;
  int        idle_left      = 0;
  int        mismatch_count = 0;
  int        cycle_count    = 0;

  byte_buffer_insert_remove_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    foreach (byte_image[i]) byte_image[i] = 8'h00;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // apply one command word to the model and work out its result word
  task automatic edit_string(input bbir_in_t w, output bbir_out_t r);
    int unsigned at;
    int unsigned n;
    int unsigned i;
    r = '0;
    r.status = ST_OK;
    case (w.cmd)
      CMD_INSERT, CMD_APPEND: begin
        at = (w.cmd == CMD_APPEND) ? fill_count : w.position;
        n  = w.length;
        if (at > fill_count) begin
          r.status = ST_RANGE;
        end else if (n != 0 && CAP - fill_count < n) begin
          r.status = ST_FULL;
        end else if (n != 0) begin
          for (i = fill_count; i > at; i--) byte_image[i - 1 + n] = byte_image[i - 1];
          for (i = 0; i < n; i++) byte_image[at + i] = w.data_byte;
          fill_count += n;
        end
      end
      CMD_REMOVE: begin
        if (w.position >= fill_count) begin
          r.status = ST_RANGE;
        end else begin
          n = w.length;
          if (n > fill_count - w.position) n = fill_count - w.position;
          for (i = w.position + n; i < fill_count; i++) byte_image[i - n] = byte_image[i];
          for (i = fill_count - n; i < fill_count; i++) byte_image[i] = 8'h00;
          fill_count -= n;
        end
      end
      CMD_CLEAR: begin
        foreach (byte_image[k]) byte_image[k] = 8'h00;
        fill_count = 0;
      end
      CMD_READ: begin
        if (w.position < fill_count) r.read_data = byte_image[w.position];
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    r.fill_level = fill_count[8:0];
  endtask

  task automatic queue_word(input logic [2:0] cmd, input int unsigned pos,
                            input int unsigned data, input int unsigned len);
    bbir_in_t w;
    w.cmd       = cmd;
    w.position  = pos[8:0];
    w.data_byte = data[7:0];
    w.length    = len[8:0];
    command_queue.push_back(w);
  endtask

  // mostly well-formed edits around the current fill, some wild fields
  task automatic queue_random_word();
    int unsigned sel;
    int unsigned grow;
    int unsigned pick;
    int unsigned len;
    int unsigned pos;
    logic [2:0]  cmd;
    sel  = $urandom_range(0, 99);
    grow = (fill_count > 200) ? 20 : 40;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(0, 8);
    else if (pick < 92) len = $urandom_range(0, 48);
    else if (pick < 97) len = $urandom_range(0, 300);
    else len = $urandom_range(0, 511);
    pos = $urandom_range(0, 511);
    if (sel < 3) begin
      cmd = CMD_CLEAR;
    end else if (sel < 5) begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_SPARE_A;
        1:       cmd = CMD_SPARE_B;
        default: cmd = CMD_SPARE_C;
      endcase
    end else if (sel < 30) begin
      cmd = CMD_READ;
      if (fill_count > 0 && $urandom_range(0, 99) < 85) pos = $urandom_range(0, fill_count - 1);
    end else if (sel < 30 + grow) begin
      cmd = ($urandom_range(0, 2) == 0) ? CMD_APPEND : CMD_INSERT;
      if ($urandom_range(0, 99) < 85) pos = $urandom_range(0, fill_count);
    end else begin
      cmd = CMD_REMOVE;
      if (fill_count > 0 && $urandom_range(0, 99) < 85) pos = $urandom_range(0, fill_count - 1);
    end
    queue_word(cmd, pos, $urandom_range(0, 255), len);
  endtask

  // driver: sends queued words in bursts, holds start until the word is taken
  always @(negedge clk) begin
    bbir_in_t next_word;
    logic     fire;
    next_word = '0;
    fire      = 1'b0;
    if (rst_n && (!start || word_taken)) begin
      if (idle_left > 0) begin
        idle_left--;
      end else if (command_queue.size() > 0) begin
        next_word = command_queue.pop_front();
        fire      = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          case ($urandom_range(0, 3))
            0:       idle_left = 0;
            1:       idle_left = $urandom_range(1, 3);
            default: idle_left = $urandom_range(4, 24);
          endcase
        end
      end
      start <= fire;
      if (fire) in_item <= next_word;
    end
  end

  // monitor: check the result word first, then predict for a newly taken word
  always @(posedge clk) begin
    bbir_out_t want;
    bbir_out_t got;
    bbir_out_t fresh;
    if (!rst_n) begin
      word_taken = 1'b0;
    end else begin
      if (out_valid === 1'b1) begin
        got = out_item;
        if (awaited_words.size() == 0) begin
          report_mismatch("result word with none awaited", got.fill_level, 0);
        end else begin
          want = awaited_words.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.fill_level !== want.fill_level)
            report_mismatch("fill_level", got.fill_level, want.fill_level);
        end
      end
      word_taken = start && (busy === 1'b0);
      if (word_taken) begin
        edit_string(in_item, fresh);
        awaited_words.push_back(fresh);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[byte_buffer_insert_remove_core] ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // empty string: out-of-range reads, removes and inserts, zero lengths
    queue_word(CMD_READ,   0,   8'h00, 0);
    queue_word(CMD_REMOVE, 0,   8'h00, 1);
    queue_word(CMD_INSERT, 1,   8'h11, 1);
    queue_word(CMD_INSERT, 0,   8'h22, 0);
    queue_word(CMD_APPEND, 0,   8'h33, 0);
    // build a short string, insert in the middle, read both ends
    queue_word(CMD_INSERT, 0,   8'hFF, 3);
    queue_word(CMD_APPEND, 511, 8'h00, 2);
    queue_word(CMD_INSERT, 2,   8'hA5, 1);
    queue_word(CMD_READ,   0,   8'h00, 0);
    queue_word(CMD_READ,   5,   8'h00, 0);
    queue_word(CMD_READ,   6,   8'h00, 0);
    // removes: plain, then one clipped at the tail
    queue_word(CMD_REMOVE, 1,   8'h00, 2);
    queue_word(CMD_REMOVE, 2,   8'h00, 511);
    queue_word(CMD_CLEAR,  0,   8'h00, 0);
    // fill to capacity and probe the full cases
    queue_word(CMD_APPEND, 0,   8'h5A, 256);
    queue_word(CMD_READ,   255, 8'h00, 0);
    queue_word(CMD_READ,   256, 8'h00, 0);
    queue_word(CMD_APPEND, 0,   8'h01, 1);
    queue_word(CMD_INSERT, 256, 8'h02, 0);
    queue_word(CMD_INSERT, 0,   8'h03, 1);
    queue_word(CMD_REMOVE, 255, 8'h00, 1);
    queue_word(CMD_INSERT, 255, 8'h04, 2);
    queue_word(CMD_INSERT, 100, 8'h81, 1);
    queue_word(CMD_REMOVE, 0,   8'h00, 511);
    // unused codes do nothing
    queue_word(CMD_SPARE_A, 0,   8'h00, 0);
    queue_word(CMD_SPARE_C, 511, 8'hFF, 511);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      // let the model settle past the edge before looking at the fill
      do begin
        @(posedge clk);
        #5;
      end while (command_queue.size() >= 2);
      queue_random_word();
    end

    while (command_queue.size() != 0 || start || awaited_words.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("[byte_buffer_insert_remove_core] OK");
    end else begin
      $display("[byte_buffer_insert_remove_core] ERROR");
    end
    $finish;
  end

endmodule
